// File: hw/rtl/rbb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbb_pkg
// Types, constants and helpers shared by the RGB 3x3 box blur modules.
// ----------------------------------------------------------------------------
package rbb_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// configuration port
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 13;
	localparam int IMG_WIDTH_W  = 11;
	localparam int IMG_HEIGHT_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// datapath widths
	localparam int PIX_W       = 24;
	localparam int SUM_W       = 12;
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = 17;
	localparam int PROD_W      = SUM_W + RECIP_W;

	typedef logic [7:0]       chan_t;
	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic load;
		logic sum;
		logic div;
		logic push;
	} ctrl_cmd_t;

	typedef struct packed {
		logic ignore;
		logic emit;
		logic out_free;
	} dp_status_t;

	// ceil(2^16 / n) for the neighbour counts that can occur; exact for sums below 2^15
	function automatic logic [RECIP_W-1:0] recip(input logic [1:0] rows, input logic [1:0] cols);
		logic [3:0] n;
		n = 4'(rows) * 4'(cols);
		case (n)
			4'd1:    recip = 17'd65536;
			4'd2:    recip = 17'd32768;
			4'd3:    recip = 17'd21846;
			4'd4:    recip = 17'd16384;
			4'd6:    recip = 17'd10923;
			4'd9:    recip = 17'd7282;
			default: recip = 17'd65536;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rbb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbb_ctrl
// Sequencer for the box blur: accept, window load, sum, divide, hand-over.
// ----------------------------------------------------------------------------
module rbb_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire rbb_pkg::dp_status_t status,
	output rbb_pkg::ctrl_cmd_t      cmd
);
	import rbb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !status.ignore) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = status.emit ? ST_SUM : ST_IDLE;
			end
			ST_SUM: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				// a flush word during the frame is taken and dropped here
				cmd.start = in_valid && !status.ignore;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
			end
			ST_OUT: begin
				cmd.push = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/rbb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbb_datapath
// Line stores, 3x3 window, position counters, masked sums, reciprocal divide
// and the output register.
// ----------------------------------------------------------------------------
module rbb_datapath #(
	parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rbb_pkg::DEF_MAX_HEIGHT
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	input  wire [rbb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [rbb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire                              action,
	input  wire [7:0]                        red_in,
	input  wire [7:0]                        green_in,
	input  wire [7:0]                        blue_in,
	input  wire rbb_pkg::ctrl_cmd_t          cmd,
	output rbb_pkg::dp_status_t              status,
	input  wire                              out_ready,
	output logic                             out_valid,
	output logic [7:0]                       red_out,
	output logic [7:0]                       green_out,
	output logic [7:0]                       blue_out,
	output logic                             frame_last
);
	import rbb_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int IW = RW + 2;
	localparam int WV = $clog2(MAX_WIDTH + 1);
	localparam int HV = $clog2(MAX_HEIGHT + 1);

	// ---------------- configuration, clamped on write ----------------
	logic [WV-1:0]           width_q;
	logic [HV-1:0]           height_q;
	logic [IMG_WIDTH_W-1:0]  wr_width;
	logic [IMG_HEIGHT_W-1:0] wr_height;

	assign wr_width  = cfg_data[IMG_WIDTH_W-1:0];
	assign wr_height = cfg_data[IMG_HEIGHT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WV'(1);
			height_q <= HV'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					if (wr_width == '0) begin
						width_q <= WV'(1);
					end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
						width_q <= WV'(MAX_WIDTH);
					end else begin
						width_q <= WV'(wr_width);
					end
				end
				REG_IMAGE_HEIGHT: begin
					if (wr_height == '0) begin
						height_q <= HV'(1);
					end else if (32'(wr_height) > 32'(MAX_HEIGHT)) begin
						height_q <= HV'(MAX_HEIGHT);
					end else begin
						height_q <= HV'(wr_height);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- position counters ----------------
	logic [CW-1:0] icol_q;
	logic [IW-1:0] irow_q;
	logic [CW-1:0] ocol_q;
	logic [RW-1:0] orow_q;
	logic          past;
	pixel_t        pix_in;

	// pixels after the frame's last act as flush words
	assign past          = 32'(irow_q) >= 32'(height_q);
	assign pix_in        = past ? '0 : {red_in, green_in, blue_in};
	assign status.ignore = action && !past;

	// ---------------- line stores ----------------
	pixel_t upper_mem [MAX_WIDTH];
	pixel_t middle_mem [MAX_WIDTH];
	pixel_t top_rd_q;
	pixel_t mid_rd_q;
	pixel_t pix_s1;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			top_rd_q <= upper_mem[icol_q];
		end
		if (cmd.load) begin
			upper_mem[icol_q] <= mid_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mid_rd_q           <= middle_mem[icol_q];
			middle_mem[icol_q] <= pix_in;
			pix_s1             <= pix_in;
		end
	end

	// ---------------- window update ----------------
	pixel_t     win_q [9];
	pixel_t     win_a [9];
	pixel_t     win_b [9];
	pixel_t     new_col [3];
	logic       col_zero;
	logic       emit_a;
	logic       emit_b;
	logic       emit;
	logic       col_end;
	logic       row_end;
	logic       last;
	logic       in_col_end;
	logic [2:0] row_ok;
	logic [2:0] col_ok;
	logic [1:0] rows;
	logic [1:0] cols;

	assign col_zero   = icol_q == '0;
	assign emit_a     = col_zero && (32'(irow_q) >= 32'd2);
	assign emit_b     = !col_zero && (irow_q != '0);
	assign emit       = emit_a || emit_b;
	assign col_end    = (32'(ocol_q) + 32'd1) >= 32'(width_q);
	assign row_end    = (32'(orow_q) + 32'd1) >= 32'(height_q);
	assign last       = emit && col_end && row_end;
	assign in_col_end = (32'(icol_q) + 32'd1) >= 32'(width_q);
	assign status.emit = emit;

	assign row_ok = {!row_end, 1'b1, orow_q != '0};
	assign col_ok = {!col_end, 1'b1, ocol_q != '0};
	assign rows   = 2'd1 + {1'b0, row_ok[0]} + {1'b0, row_ok[2]};
	assign cols   = 2'd1 + {1'b0, col_ok[0]} + {1'b0, col_ok[2]};

	always_comb begin
		new_col[0] = top_rd_q;
		new_col[1] = mid_rd_q;
		new_col[2] = pix_s1;
		for (int r = 0; r < 3; r++) begin
			// a new row first pushes an empty column in
			win_a[r*3]     = col_zero ? win_q[r*3+1] : win_q[r*3];
			win_a[r*3 + 1] = col_zero ? win_q[r*3+2] : win_q[r*3+1];
			win_a[r*3 + 2] = col_zero ? '0 : win_q[r*3+2];
			win_b[r*3]     = win_a[r*3+1];
			win_b[r*3 + 1] = win_a[r*3+2];
			win_b[r*3 + 2] = new_col[r];
		end
	end

	pixel_t     ewin_s1 [9];
	logic [1:0] rows_s1;
	logic [1:0] cols_s1;
	logic       last_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= (emit_a && last) ? win_a[i] : win_b[i];
			end
			if (emit) begin
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						ewin_s1[r*3 + c] <= (row_ok[r] && col_ok[c]) ?
							(emit_a ? win_a[r*3 + c] : win_b[r*3 + c]) : '0;
					end
				end
				rows_s1 <= rows;
				cols_s1 <= cols;
				last_s1 <= last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icol_q <= '0;
			irow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cmd.load) begin
			if (last) begin
				icol_q <= '0;
				irow_q <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				if (emit) begin
					if (col_end) begin
						ocol_q <= '0;
						orow_q <= orow_q + RW'(1);
					end else begin
						ocol_q <= ocol_q + CW'(1);
					end
				end
				if (in_col_end) begin
					icol_q <= '0;
					// row count saturates while a frame drains
					if (irow_q != '1) begin
						irow_q <= irow_q + IW'(1);
					end
				end else begin
					icol_q <= icol_q + CW'(1);
				end
			end
		end
	end

	// ---------------- sum and reciprocal divide ----------------
	logic [SUM_W-1:0]   sum_red;
	logic [SUM_W-1:0]   sum_green;
	logic [SUM_W-1:0]   sum_blue;
	logic [SUM_W-1:0]   sum_red_s2;
	logic [SUM_W-1:0]   sum_green_s2;
	logic [SUM_W-1:0]   sum_blue_s2;
	logic [RECIP_W-1:0] recip_s2;
	logic               last_s2;

	always_comb begin
		sum_red   = '0;
		sum_green = '0;
		sum_blue  = '0;
		for (int i = 0; i < 9; i++) begin
			sum_red   = sum_red   + SUM_W'(ewin_s1[i][23:16]);
			sum_green = sum_green + SUM_W'(ewin_s1[i][15:8]);
			sum_blue  = sum_blue  + SUM_W'(ewin_s1[i][7:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sum_red_s2   <= sum_red;
			sum_green_s2 <= sum_green;
			sum_blue_s2  <= sum_blue;
			recip_s2     <= recip(rows_s1, cols_s1);
			last_s2      <= last_s1;
		end
	end

	logic [PROD_W-1:0] prod_red;
	logic [PROD_W-1:0] prod_green;
	logic [PROD_W-1:0] prod_blue;
	chan_t             red_s3;
	chan_t             green_s3;
	chan_t             blue_s3;
	logic              last_s3;

	assign prod_red   = PROD_W'(sum_red_s2)   * PROD_W'(recip_s2);
	assign prod_green = PROD_W'(sum_green_s2) * PROD_W'(recip_s2);
	assign prod_blue  = PROD_W'(sum_blue_s2)  * PROD_W'(recip_s2);

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			red_s3   <= prod_red[RECIP_SHIFT +: 8];
			green_s3 <= prod_green[RECIP_SHIFT +: 8];
			blue_s3  <= prod_blue[RECIP_SHIFT +: 8];
			last_s3  <= last_s2;
		end
	end

	// ---------------- output register ----------------
	logic  out_valid_q;
	chan_t red_out_q;
	chan_t green_out_q;
	chan_t blue_out_q;
	logic  frame_last_q;

	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			red_out_q    <= red_s3;
			green_out_q  <= green_s3;
			blue_out_q   <= blue_s3;
			frame_last_q <= last_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign red_out    = red_out_q;
	assign green_out  = green_out_q;
	assign blue_out   = blue_out_q;
	assign frame_last = frame_last_q;

endmodule
`default_nettype wire

// File: hw/rtl/rgb_box_blur_3x3_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_unit
// Streaming 3x3 box blur on 8-bit RGB pixels in raster order. Pixels arrive as
// words with action 0, and each output word is the per-channel truncated mean
// of the neighbours of one pixel that lie inside the frame (divisor 4, 6 or 9,
// fewer on frames one pixel wide or high), one row plus one pixel behind the
// input. After the frame's last pixel, words with action 1 drain the remaining
// results; the final one carries frame_last, and the next pixel starts a new
// frame. A flush word while pixels are still expected is taken and dropped.
// A sequencer handles one word at a time, taking none until the last is done:
// a word that gives no result goes through accept, then window load after the
// registered line store read; one that gives a result goes through accept,
// load, sum, reciprocal divide and hand-over to the output register, held
// while that register is full. Line stores need no clearing pass after reset.
// image_width (index 0) and image_height (index 1) are clamped to 1..MAX_WIDTH
// and 1..MAX_HEIGHT, to be written while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3_unit #(
	parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rbb_pkg::DEF_MAX_HEIGHT
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [rbb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire                           action,
	input  wire [7:0]                     red_in,
	input  wire [7:0]                     green_in,
	input  wire [7:0]                     blue_in,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [7:0]                    red_out,
	output logic [7:0]                    green_out,
	output logic [7:0]                    blue_out,
	output logic                          frame_last
);
	import rbb_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	rbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rbb_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.action     (action),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.cmd        (cmd),
		.status     (status),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.frame_last (frame_last)
	);

	// a result never lands on a word still waiting to be taken
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid || out_ready))
		else $error("result pushed over a pending output word");

	a_start_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (cmd.load && !in_ready))
		else $error("accepted word not followed by window load");

	a_emit_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && status.emit) |=> cmd.sum ##1 cmd.div)
		else $error("result did not go through sum and divide");

endmodule
`default_nettype wire

// File: verif/rgb_box_blur_3x3_unit_test.sv
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_unit_test
// Self-checking bench for the streaming RGB 3x3 box blur. Pixel and flush
// words go in over a valid/ready port and blurred words come back. Every
// accepted word runs through a model of the line stores, the window and the
// border divisors held in a scoreboard. Each returned word is compared field
// by field with the oldest predicted mean. Frame sizes are changed between
// frames and once in a while part way through one.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3_unit_test;
	import rbb_pkg::*;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int RANDOM_WORDS    = 1050;

	localparam chan_t PATTERN_BYTES [8] = '{8'h00, 8'hFF, 8'hAA, 8'h55,
		8'h01, 8'h80, 8'h7F, 8'hFE};

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  last;
	} blur_mean_t;

	class blur_scoreboard;
		pixel_t upper_line [DEF_MAX_WIDTH];
		pixel_t middle_line [DEF_MAX_WIDTH];
		pixel_t win [9];
		int unsigned in_col, in_row, out_col, out_row;
		logic [IMG_WIDTH_W-1:0]  width_reg;
		logic [IMG_HEIGHT_W-1:0] height_reg;
		blur_mean_t expected_means [$];
		int unsigned words_used, checked, frames, mismatches, reg_writes;

		function new();
			for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			for (int i = 0; i < 9; i++)
				win[i] = '0;
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			width_reg = IMG_WIDTH_W'(1);
			height_reg = IMG_HEIGHT_W'(1);
			words_used = 0;
			checked = 0;
			frames = 0;
			mismatches = 0;
			reg_writes = 0;
		endfunction

		function int unsigned frame_width();
			int unsigned v;
			v = 32'(width_reg);
			if (v == 0)
				return 1;
			if (v > DEF_MAX_WIDTH)
				return DEF_MAX_WIDTH;
			return v;
		endfunction

		function int unsigned frame_height();
			int unsigned v;
			v = 32'(height_reg);
			if (v == 0)
				return 1;
			if (v > DEF_MAX_HEIGHT)
				return DEF_MAX_HEIGHT;
			return v;
		endfunction

		function bit draining();
			return in_row >= frame_height();
		endfunction

		function int unsigned pending();
			return expected_means.size();
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			reg_writes++;
			if (idx == REG_IMAGE_WIDTH)
				width_reg = value[IMG_WIDTH_W-1:0];
			else if (idx == REG_IMAGE_HEIGHT)
				height_reg = value[IMG_HEIGHT_W-1:0];
		endfunction

		// new column enters on the right, rows top to bottom
		function void shift_column(pixel_t top, pixel_t mid, pixel_t bot);
			win[0] = win[1];
			win[1] = win[2];
			win[2] = top;
			win[3] = win[4];
			win[4] = win[5];
			win[5] = mid;
			win[6] = win[7];
			win[7] = win[8];
			win[8] = bot;
		endfunction

		// mean around the output position; returns 1 at the end of the frame
		function bit predict_mean();
			int unsigned w, h, sum_r, sum_g, sum_b, cnt, r, c;
			bit row_ok [3];
			bit col_ok [3];
			blur_mean_t mean;
			w = frame_width();
			h = frame_height();
			row_ok[0] = out_row >= 1;
			row_ok[1] = 1'b1;
			row_ok[2] = out_row + 1 < h;
			col_ok[0] = out_col >= 1;
			col_ok[1] = 1'b1;
			col_ok[2] = out_col + 1 < w;
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			cnt = 0;
			for (r = 0; r < 3; r++)
				for (c = 0; c < 3; c++)
					if (row_ok[r] && col_ok[c]) begin
						sum_r += 32'(win[r*3+c][23:16]);
						sum_g += 32'(win[r*3+c][15:8]);
						sum_b += 32'(win[r*3+c][7:0]);
						cnt++;
					end
			mean.red = 8'(sum_r / cnt);
			mean.green = 8'(sum_g / cnt);
			mean.blue = 8'(sum_b / cnt);
			mean.last = (out_col + 1 >= w) && (out_row + 1 >= h);
			expected_means.push_back(mean);
			if (mean.last) begin
				in_col = 0;
				in_row = 0;
				out_col = 0;
				out_row = 0;
			end else if (out_col + 1 >= w) begin
				out_col = 0;
				out_row++;
			end else begin
				out_col++;
			end
			return mean.last;
		endfunction

		function void take_word(logic act, chan_t r, chan_t g, chan_t b);
			int unsigned w, h, ic, ir, col;
			bit past;
			pixel_t pix, top, mid;
			w = frame_width();
			h = frame_height();
			ic = in_col;
			ir = in_row;
			past = ir >= h;
			// flush while the frame still wants pixels is dropped
			if (act == ACT_FLUSH && !past)
				return;
			words_used++;
			pix = past ? '0 : {r, g, b};
			col = (ic < DEF_MAX_WIDTH) ? ic : DEF_MAX_WIDTH - 1;
			top = upper_line[col];
			mid = middle_line[col];
			upper_line[col] = mid;
			middle_line[col] = pix;
			if (ic == 0) begin
				shift_column('0, '0, '0);
				if (ir >= 2 && predict_mean())
					return;
			end
			shift_column(top, mid, pix);
			if (ic >= 1 && ir >= 1 && predict_mean())
				return;
			if (ic + 1 >= w) begin
				in_col = 0;
				in_row = ir + 1;
			end else begin
				in_col = ic + 1;
			end
		endfunction

		function void check_mean(chan_t r, chan_t g, chan_t b, logic last);
			blur_mean_t want;
			if (expected_means.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected word r=%02h g=%02h b=%02h last=%0b",
						$time, r, g, b, last);
				return;
			end
			want = expected_means.pop_front();
			checked++;
			if (want.last)
				frames++;
			if (want.red !== r || want.green !== g || want.blue !== b || want.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mean mismatch, want r=%02h g=%02h b=%02h last=%0b,",
						$time, want.red, want.green, want.blue, want.last,
						" got r=%02h g=%02h b=%02h last=%0b", r, g, b, last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	chan_t red_in = '0;
	chan_t green_in = '0;
	chan_t blue_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	chan_t red_out, green_out, blue_out;
	logic frame_last;

	blur_scoreboard blur_sb;
	bit send_gaps = 1'b0;
	bit recv_stalls = 1'b0;
	bit hold_off_req = 1'b0;
	int unsigned quiet_cycles = 0;

	rgb_box_blur_3x3_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.frame_last(frame_last)
	);

	always #4 clk = ~clk;

	task automatic send_word(logic act, chan_t r, chan_t g, chan_t b);
		if (send_gaps && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do @(posedge clk); while (!in_ready);
		blur_sb.take_word(act, r, g, b);
	endtask

	task automatic send_pattern(int unsigned i);
		send_word(ACT_PIXEL, PATTERN_BYTES[i % 8], PATTERN_BYTES[(i + 3) % 8],
			PATTERN_BYTES[(i + 6) % 8]);
	endtask

	task automatic send_random_pixel();
		send_word(ACT_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_flush();
		send_word(ACT_FLUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// stop sending and let every predicted word come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (blur_sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		blur_sb.set_register(idx, value);
		@(posedge clk);
	endtask

	// late pixels count as flush words once the frame is complete
	task automatic drain_frame();
		while (blur_sb.draining()) begin
			if ($urandom_range(0, 4) == 0)
				send_random_pixel();
			else
				send_random_flush();
		end
	endtask

	function automatic int unsigned pick_size(int unsigned typical, int unsigned big);
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 2)
			return 0;
		if (roll < 4)
			return $urandom_range(typical + 1, big);
		return $urandom_range(1, typical);
	endfunction

	task automatic run_directed();
		// flush before any pixel of the frame
		send_word(ACT_FLUSH, 8'hFF, 8'h00, 8'hA5);
		// one pixel frame at the reset sizes
		send_word(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		send_word(ACT_FLUSH, 8'h00, 8'h00, 8'h00);
		send_word(ACT_PIXEL, 8'h12, 8'h34, 8'h56);
		wait_idle();
		// zero width is taken as one
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
		send_pattern(0);
		send_pattern(1);
		drain_frame();
		wait_idle();
		// height above the maximum, then cut down part way through the frame
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
		for (int i = 2; i < 5; i++)
			send_pattern(i);
		send_word(ACT_FLUSH, 8'h00, 8'hFF, 8'h00);
		for (int i = 5; i < 8; i++)
			send_pattern(i);
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
		for (int i = 8; i < 11; i++)
			send_pattern(i);
		drain_frame();
	endtask

	task automatic run_random_frames(int unsigned target);
		int unsigned start_words, frame_no, cut_at, in_frame;
		start_words = blur_sb.words_used;
		frame_no = 0;
		while (blur_sb.words_used - start_words < target) begin
			send_gaps = $urandom_range(0, 3) != 0;
			recv_stalls = $urandom_range(0, 3) != 0;
			if (frame_no == 3) begin
				// long enough to back the block up while the output is held off
				wait_idle();
				write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(6));
				write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(5));
				hold_off_req = 1'b1;
			end else if (frame_no == 0 || $urandom_range(0, 2) == 0) begin
				wait_idle();
				write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(pick_size(8, 40)));
				write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(pick_size(6, 16)));
			end
			cut_at = 0;
			if ($urandom_range(0, 7) == 0)
				cut_at = $urandom_range(1, blur_sb.frame_width() * blur_sb.frame_height());
			in_frame = 0;
			while (!blur_sb.draining()) begin
				if ($urandom_range(0, 19) == 0) begin
					send_random_flush();
				end else begin
					send_random_pixel();
					in_frame++;
					// size change mid-frame: width never grows, rows may go either way
					if (in_frame == cut_at && !blur_sb.draining()) begin
						wait_idle();
						if ($urandom_range(0, 1) == 0)
							write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(
								$urandom_range(0, blur_sb.frame_height() + 2)));
						else
							write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(
								$urandom_range(0, blur_sb.frame_width())));
					end
				end
			end
			drain_frame();
			frame_no++;
		end
	endtask

	task automatic run_frame(logic [CFG_DATA_W-1:0] width_word,
			logic [CFG_DATA_W-1:0] height_word);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, width_word);
		write_reg(REG_IMAGE_HEIGHT, height_word);
		while (!blur_sb.draining())
			send_random_pixel();
		drain_frame();
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			blur_sb.check_mean(red_out, green_out, blue_out, frame_last);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("stuck for %0d cycles, %0d words outstanding", quiet_cycles,
					blur_sb.pending());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// output side: random stalls plus one long hold-off on request
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (recv_stalls && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		blur_sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random_frames(RANDOM_WORDS);
		// closing frames run without gaps or stalls
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		// bits above the width register are dropped
		run_frame(13'h1804, 13'd3);
		wait_idle();
		repeat (16) @(posedge clk);
		$display("run covered %0d words used, %0d blurred words checked, %0d frames",
			blur_sb.words_used, blur_sb.checked, blur_sb.frames);
		$display("%0d register writes, %0d mismatches, %0d words outstanding",
			blur_sb.reg_writes, blur_sb.mismatches, blur_sb.pending());
		if (blur_sb.mismatches == 0 && blur_sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/rbb_pkg.sv
hw/rtl/rbb_ctrl.sv
hw/rtl/rbb_datapath.sv
hw/rtl/rgb_box_blur_3x3_unit.sv
verif/rgb_box_blur_3x3_unit_test.sv
